@@ sv/bfp_pkg.sv @@
// Shared types, sizes and character codes for the Brainfuck processor core.
`default_nettype none
package bfp_pkg;

   localparam int PROGRAM_DEPTH = 4096;
   localparam int CELL_COUNT    = 32768;
   localparam int NEST_DEPTH    = 1024;

   localparam int PA_W    = $clog2(PROGRAM_DEPTH);
   localparam int PL_W    = $clog2(PROGRAM_DEPTH + 1);
   localparam int CA_W    = $clog2(CELL_COUNT);
   localparam int SA_W    = $clog2(NEST_DEPTH);
   localparam int SD_W    = $clog2(NEST_DEPTH + 1);
   localparam int INSTR_W = 13;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_PREPARE = 2'd2,
      OP_STEP    = 2'd3
   } op_type;

   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_DEEP       = 3'd1;
   localparam logic [2:0] ERR_CLOSE      = 3'd2;
   localparam logic [2:0] ERR_OPEN       = 3'd3;
   localparam logic [2:0] ERR_UNPREPARED = 3'd4;

   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef struct packed {
      op_type     op;
      logic [7:0] program_byte;
      logic [7:0] input_byte;
      logic       input_present;
   } req_type;

   typedef struct packed {
      logic               out_valid;
      logic [7:0]         out_byte;
      logic               halted;
      logic [2:0]         error_code;
      logic [INSTR_W-1:0] instr_position;
      logic               used_input;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/bfp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/brainfuck_processor_core.sv @@
// Top level of the Brainfuck processor core: sequencer, pointers and the four memories.
`default_nettype none
// The core takes one request transaction at a time and answers each with
// exactly one response transaction. An append writes its byte into the
// program memory while there is room, then loads the response register. A
// step reads the instruction, the match entry and the current cell from
// their memories, then executes and writes the cell back, and then loads the
// response register. A prepare walks the program one character at a time
// through ST_PREP_RD and ST_PREP_EX; every ']' also passes through
// ST_PREP_POP and ST_PREP_LINK (stack pop, then the two match table writes
// through the single write port). A clear sweeps the whole data cell
// memory, one cell a cycle. After reset the same sweep runs without a
// response, and no request is accepted until it ends. The response register
// lets the next request be accepted while an earlier response is still stalled.
module brainfuck_processor_core
   import bfp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CLEAR     = 8'b0000_0010,
      ST_PREP_RD   = 8'b0000_0100,
      ST_PREP_EX   = 8'b0000_1000,
      ST_PREP_POP  = 8'b0001_0000,
      ST_PREP_LINK = 8'b0010_0000,
      ST_STEP_EX   = 8'b0100_0000,
      ST_RESP      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Architectural registers.
   logic [CA_W-1:0] dp_ff, dp_in;
   logic [PL_W-1:0] ip_ff, ip_in;
   logic [PL_W-1:0] len_ff, len_in;
   logic            prepared_ff, prepared_in;

   // Sequencer working registers.
   logic [CA_W-1:0] clr_ff, clr_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic [PL_W-1:0] pos_ff, pos_in;
   logic [SD_W-1:0] depth_ff, depth_in;
   logic [PA_W-1:0] open_ff, open_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_present_ff, in_present_in;

   // Pending result fields, moved into the response register in ST_RESP.
   logic            ov_ff, ov_in;
   logic [7:0]      ob_ff, ob_in;
   logic [2:0]      err_ff, err_in;
   logic            used_ff, used_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic            prog_we;
   logic [PA_W-1:0] prog_waddr, prog_raddr;
   logic [7:0]      prog_wdata, prog_rdata;
   logic            match_we;
   logic [PA_W-1:0] match_waddr, match_wdata, match_raddr, match_rdata;
   logic            stack_we;
   logic [SA_W-1:0] stack_waddr, stack_raddr;
   logic [PA_W-1:0] stack_wdata, stack_rdata;
   logic            cell_we;
   logic [CA_W-1:0] cell_waddr;
   logic [7:0]      cell_wdata, cell_rdata;

   logic            req_fire;
   logic            rsp_free;

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Read addresses come straight from the registers, so a step issues its
   // three reads in the cycle in which the request transaction is accepted.
   assign prog_raddr  = (state_ff == ST_PREP_RD) ? pos_ff[PA_W-1:0] : ip_ff[PA_W-1:0];
   assign match_raddr = ip_ff[PA_W-1:0];
   assign stack_raddr = SA_W'(depth_ff - 1'b1);

   bfp_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_waddr),
      .wr_data (prog_wdata),
      .rd_addr (prog_raddr),
      .rd_data (prog_rdata)
   );

   bfp_ram #(.WIDTH(PA_W), .DEPTH(PROGRAM_DEPTH)) u_match (
      .clock   (clock),
      .wr_en   (match_we),
      .wr_addr (match_waddr),
      .wr_data (match_wdata),
      .rd_addr (match_raddr),
      .rd_data (match_rdata)
   );

   bfp_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   bfp_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_cells (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_addr (dp_ff),
      .rd_data (cell_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      dp_in         = dp_ff;
      ip_in         = ip_ff;
      len_in        = len_ff;
      prepared_in   = prepared_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      pos_in        = pos_ff;
      depth_in      = depth_ff;
      open_in       = open_ff;
      in_byte_in    = in_byte_ff;
      in_present_in = in_present_ff;
      ov_in         = ov_ff;
      ob_in         = ob_ff;
      err_in        = err_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      prog_we     = 1'b0;
      prog_waddr  = len_ff[PA_W-1:0];
      prog_wdata  = req_data.program_byte;
      match_we    = 1'b0;
      match_waddr = pos_ff[PA_W-1:0];
      match_wdata = stack_rdata;
      stack_we    = 1'b0;
      stack_waddr = depth_ff[SA_W-1:0];
      stack_wdata = pos_ff[PA_W-1:0];
      cell_we     = 1'b0;
      cell_waddr  = dp_ff;
      cell_wdata  = cell_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ov_in         = 1'b0;
               ob_in         = 8'd0;
               err_in        = ERR_OK;
               used_in       = 1'b0;
               in_byte_in    = req_data.input_byte;
               in_present_in = req_data.input_present;
               case (req_data.op)
                  OP_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  OP_APPEND: begin
                     if (len_ff < PL_W'(PROGRAM_DEPTH)) begin
                        prog_we = 1'b1;
                        len_in  = len_ff + 1'b1;
                     end
                     prepared_in = 1'b0;
                     state_in    = ST_RESP;
                  end
                  OP_PREPARE: begin
                     pos_in   = '0;
                     depth_in = '0;
                     state_in = ST_PREP_RD;
                  end
                  OP_STEP: begin
                     if (!prepared_ff) begin
                        err_in   = ERR_UNPREPARED;
                        state_in = ST_RESP;
                     end else if (ip_ff < len_ff) begin
                        state_in = ST_STEP_EX;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = 8'd0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CA_W'(CELL_COUNT - 1)) begin
               dp_in       = '0;
               ip_in       = '0;
               len_in      = '0;
               prepared_in = 1'b0;
               state_in    = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end

         ST_PREP_RD: begin
            if (pos_ff >= len_ff) begin
               err_in      = (depth_ff != '0) ? ERR_OPEN : ERR_OK;
               prepared_in = (depth_ff == '0);
               ip_in       = '0;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_PREP_EX;
            end
         end

         ST_PREP_EX: begin
            case (prog_rdata)
               CH_OPEN: begin
                  if (depth_ff == SD_W'(NEST_DEPTH)) begin
                     err_in      = ERR_DEEP;
                     prepared_in = 1'b0;
                     ip_in       = '0;
                     state_in    = ST_RESP;
                  end else begin
                     stack_we = 1'b1;
                     depth_in = depth_ff + 1'b1;
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_PREP_RD;
                  end
               end
               CH_CLOSE: begin
                  if (depth_ff == '0) begin
                     err_in      = ERR_CLOSE;
                     prepared_in = 1'b0;
                     ip_in       = '0;
                     state_in    = ST_RESP;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                     state_in = ST_PREP_POP;
                  end
               end
               default: begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_PREP_RD;
               end
            endcase
         end

         ST_PREP_POP: begin
            match_we = 1'b1;
            open_in  = stack_rdata;
            state_in = ST_PREP_LINK;
         end

         ST_PREP_LINK: begin
            match_we    = 1'b1;
            match_waddr = open_ff;
            match_wdata = pos_ff[PA_W-1:0];
            pos_in      = pos_ff + 1'b1;
            state_in    = ST_PREP_RD;
         end

         ST_STEP_EX: begin
            ip_in = ip_ff + 1'b1;
            case (prog_rdata)
               CH_RIGHT: dp_in = (dp_ff == CA_W'(CELL_COUNT - 1)) ? '0 : dp_ff + 1'b1;
               CH_LEFT:  dp_in = (dp_ff == '0) ? CA_W'(CELL_COUNT - 1) : dp_ff - 1'b1;
               CH_INC: begin
                  cell_we    = 1'b1;
                  cell_wdata = cell_rdata + 8'd1;
               end
               CH_DEC: begin
                  cell_we    = 1'b1;
                  cell_wdata = cell_rdata - 8'd1;
               end
               CH_OUT: begin
                  ov_in = 1'b1;
                  ob_in = cell_rdata;
               end
               CH_IN: begin
                  if (in_present_ff) begin
                     cell_we    = 1'b1;
                     cell_wdata = in_byte_ff;
                     used_in    = 1'b1;
                  end
               end
               CH_OPEN: begin
                  if (cell_rdata == 8'd0) begin
                     ip_in = PL_W'(match_rdata) + 1'b1;
                  end
               end
               CH_CLOSE: begin
                  if (cell_rdata != 8'd0) begin
                     ip_in = PL_W'(match_rdata) + 1'b1;
                  end
               end
               default: ;
            endcase
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_valid      = ov_ff;
               rsp_data_in.out_byte       = ob_ff;
               rsp_data_in.halted         = (ip_ff >= len_ff);
               rsp_data_in.error_code     = err_ff;
               rsp_data_in.instr_position = INSTR_W'(ip_ff);
               rsp_data_in.used_input     = used_ff;
               state_in                   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         dp_ff        <= '0;
         ip_ff        <= '0;
         len_ff       <= '0;
         prepared_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         dp_ff        <= dp_in;
         ip_ff        <= ip_in;
         len_ff       <= len_in;
         prepared_ff  <= prepared_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      depth_ff      <= depth_in;
      open_ff       <= open_in;
      in_byte_ff    <= in_byte_in;
      in_present_ff <= in_present_in;
      ov_ff         <= ov_in;
      ob_ff         <= ob_in;
      err_ff        <= err_in;
      used_ff       <= used_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The program length never runs past the program memory.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= PL_W'(PROGRAM_DEPTH))
      else $error("program length beyond program memory");

   // An accepted request transaction always leaves the idle state.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request accepted without starting work");

   // An emitted byte only comes from a step that raised no error.
   a_out_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> rsp_data.error_code == ERR_OK)
      else $error("output byte together with an error");
`endif

endmodule
`default_nettype wire
